>>> rtl/gbn_pkg.sv
// Package: shared constants, codes, state types and fixed-point helpers.
`default_nettype none
package gbn_pkg;

  localparam int WEIGHT_SLOTS_DEF = 1024;
  localparam int SUM_SLOTS_DEF    = 128;
  localparam int INPUT_COUNT_DEF  = 7;

  localparam int Q_W      = 32;
  localparam int LR_W     = 25;
  localparam int OP_W     = 4;
  localparam int OFF_W    = 10;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int GIN_N    = 7;

  localparam logic [LR_W-1:0] LR_RESET    = LR_W'(168);
  localparam logic [31:0]     LFSR_MASK   = 32'h8020_0003;
  localparam logic [31:0]     DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int              DIV10_SHIFT = 35;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_THINK          = 4'd0,
    OP_NEW_WEIGHT     = 4'd1,
    OP_NEW_SUM        = 4'd2,
    OP_SUM_TO_IN      = 4'd3,
    OP_SUM_TO_CTRL    = 4'd4,
    OP_WEIGHT_TO_SUM  = 4'd5,
    OP_WEIGHT_TO_CTRL = 4'd6,
    OP_POP_WEIGHT     = 4'd7,
    OP_POP_SUM        = 4'd8,
    OP_GLOBAL_TO_IN   = 4'd9,
    OP_SUM_TO_RESULT  = 4'd10,
    OP_CLEAR_BUILD    = 4'd11,
    OP_START_PLAY     = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SUM    = 2'd1,
    KIND_WEIGHT = 2'd2,
    KIND_GLOBAL = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_WEIGHT_FULL = 3'd1,
    ST_SUM_FULL    = 3'd2,
    ST_INDEX_RANGE = 3'd3,
    ST_UNKNOWN_OP  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SW_RESET,
    SW_CLEAR,
    SW_PLAY
  } sweep_t;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_DISP,
    S_B_WR, S_B_RD2, S_B_WR2,
    S_A_RD, S_A_SRD, S_A_MUL, S_A_WR,
    S_C_CLR,
    S_D_RD, S_D_SRD, S_D_WR,
    S_E_RD, S_E_MUL, S_E_WR,
    S_F_RD, S_F_XRD, S_F_MUL, S_F_RND, S_F_WR,
    S_FIN_RD, S_FIN_OUT
  } state_t;

  // Q8.24 product rounding: nearest on the magnitude, ties away, saturating.
  function automatic logic signed [31:0] q_round(input logic signed [63:0] p);
    logic        neg;
    logic [63:0] m;
    logic [39:0] r;
    neg = p[63];
    m   = neg ? 64'(-p) : 64'(p);
    m   = m + 64'h80_0000;
    r   = m[63:24];
    if (!neg) begin
      q_round = (r > 40'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(r[31:0]);
    end else if (r >= 40'h8000_0000) begin
      q_round = signed'({1'b1, 31'b0});
    end else begin
      q_round = signed'(32'(-r[31:0]));
    end
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? signed'({1'b1, 31'b0}) : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/gbn_if.sv
// Interfaces: command channel and result channel.
`default_nettype none
interface gbn_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         op;
  logic [9:0]         offset;
  logic signed [31:0] red_x;
  logic signed [31:0] red_y;
  logic signed [31:0] blue_x;
  logic signed [31:0] blue_y;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic signed [31:0] energy;
  modport source (output valid, op, offset, red_x, red_y, blue_x, blue_y,
                  query_x, query_y, energy, input ready);
  modport sink   (input valid, op, offset, red_x, red_y, blue_x, blue_y,
                  query_x, query_y, energy, output ready);
endinterface

interface gbn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [2:0]         status;
  modport source (output valid, out_value, status, input ready);
  modport sink   (input valid, out_value, status, output ready);
endinterface
`default_nettype wire

>>> rtl/gbn_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none
module gbn_ram #(
  parameter int DEPTH = gbn_pkg::SUM_SLOTS_DEF,
  parameter int WIDTH = gbn_pkg::Q_W,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/gbn_mul.sv
// Shared signed 33x33 multiplier with registered product.
`default_nettype none
module gbn_mul (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [63:0]      p_r
);
  logic signed [65:0] full;
  assign full = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= full[63:0];
    end
  end
endmodule
`default_nettype wire

>>> rtl/gene_built_net_step_engine_top.sv
// Top level: network build/think sequencer around the state memories.
//
// Usage. Command items arrive on in_chan (valid/ready); every item gives one
// result on out_chan: out_value is the sum unit wired to the result, status
// the outcome code. Registers are written on the cfg port (learning rate,
// generator seed); the user must write them only while the block is idle,
// which the block itself does not enforce.
// Clear build and start play run a pass over max(WEIGHT_SLOTS, SUM_SLOTS)
// entries. Think walks the used weights to load and multiply, zeroes the
// used sum units, accumulates weight outputs into their sums, leaks the
// negative sums and then updates coefficients from their controls.
// All state sits in four one-port-read memories; every phase walks them one
// entry at a time, mostly read-modify-write, so the memory ports set the pace.
// One item is in flight at a time; the next command transfer is taken as soon
// as the result sits in the output register, even while out_chan stalls.
// Reset: a clearing pass over max(WEIGHT_SLOTS, SUM_SLOTS) entries zeroes the
// wiring, coefficients and values; in_chan.ready stays low until it ends.
// A stalled receiver holds the result; the block then waits before loading
// the next one.
`default_nettype none
module gene_built_net_step_engine_top #(
  parameter int WEIGHT_SLOTS = gbn_pkg::WEIGHT_SLOTS_DEF,
  parameter int SUM_SLOTS    = gbn_pkg::SUM_SLOTS_DEF,
  parameter int INPUT_COUNT  = gbn_pkg::INPUT_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  gbn_in_if.sink                             in_chan,
  gbn_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);
  import gbn_pkg::*;

  localparam int WIW  = $clog2(WEIGHT_SLOTS);
  localparam int SIW  = $clog2(SUM_SLOTS);
  localparam int IXA  = (WIW > SIW) ? WIW : SIW;
  localparam int IXW  = (IXA > 3) ? IXA : 3;
  localparam int LW   = 3 * (2 + IXW);
  localparam int SWEEP_N = (WEIGHT_SLOTS > SUM_SLOTS) ? WEIGHT_SLOTS : SUM_SLOTS;
  localparam int SWW  = $clog2(SWEEP_N);
  localparam int CMPW = (WIW > OFF_W) ? WIW : OFF_W;
  // link word layout: out kind/ix, in kind/ix, control kind/ix
  localparam int CIX = 0;
  localparam int CK  = IXW;
  localparam int IIX = IXW + 2;
  localparam int IK  = 2 * IXW + 2;
  localparam int OIX = 2 * IXW + 4;
  localparam int OK  = 3 * IXW + 4;

  state_t state_r, state_nxt;
  sweep_t sw_mode_r;
  logic [SWW-1:0] sw_r, sw_nxt;
  logic [WIW-1:0] cnt_r, cnt_nxt;
  logic [SIW-1:0] sc_r, sc_nxt;

  logic [WIW-1:0] tw_r, hw_r;
  logic [SIW-1:0] ts_r, hs_r, rs_r;
  logic [LR_W-1:0] lr_r;
  logic [31:0]     lfsr_r;

  logic [OP_W-1:0]    op_r;
  logic [OFF_W-1:0]   off_r;
  logic signed [31:0] gin_r [GIN_N];
  status_t            status_r;

  logic [LW-1:0]      lk_r;
  logic signed [31:0] coef_r, wv_r, q_r;
  logic               neg_r;

  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [STATUS_W-1:0] out_status_r;

  // memory ports
  logic           w_re, w_we, c_re, c_we, v_re, v_we, s_re, s_we;
  logic [WIW-1:0] w_raddr, w_waddr, c_raddr, c_waddr, v_raddr, v_waddr;
  logic [SIW-1:0] s_raddr, s_waddr;
  logic [LW-1:0]  w_rdata, w_wdata;
  logic [31:0]    c_rdata, c_wdata, v_rdata, v_wdata, s_rdata, s_wdata;

  logic               mul_en;
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] prod;

  gbn_ram #(.DEPTH(WEIGHT_SLOTS), .WIDTH(LW)) u_wiring (
    .clk, .re(w_re), .raddr(w_raddr), .rdata(w_rdata),
    .we(w_we), .waddr(w_waddr), .wdata(w_wdata));
  gbn_ram #(.DEPTH(WEIGHT_SLOTS), .WIDTH(Q_W)) u_coef (
    .clk, .re(c_re), .raddr(c_raddr), .rdata(c_rdata),
    .we(c_we), .waddr(c_waddr), .wdata(c_wdata));
  gbn_ram #(.DEPTH(WEIGHT_SLOTS), .WIDTH(Q_W)) u_wval (
    .clk, .re(v_re), .raddr(v_raddr), .rdata(v_rdata),
    .we(v_we), .waddr(v_waddr), .wdata(v_wdata));
  gbn_ram #(.DEPTH(SUM_SLOTS), .WIDTH(Q_W)) u_sval (
    .clk, .re(s_re), .raddr(s_raddr), .rdata(s_rdata),
    .we(s_we), .waddr(s_waddr), .wdata(s_wdata));

  gbn_mul u_mul (.clk, .en(mul_en), .a(mul_a), .b(mul_b), .p_r(prod));

  // stack-relative targets
  logic           pw_ok, ps_ok, gin_ok;
  logic [WIW-1:0] pw;
  logic [SIW-1:0] ps;
  assign pw_ok  = CMPW'(off_r) < CMPW'(tw_r);
  assign ps_ok  = OFF_W'(ts_r) > off_r;
  assign gin_ok = off_r < OFF_W'(INPUT_COUNT);
  assign pw     = WIW'(CMPW'(tw_r) - CMPW'(off_r));
  assign ps     = SIW'(OFF_W'(ts_r) - off_r);

  // fields of the freshly read and the held link word
  kind_t          rd_ik, rd_ok, rd_ck, lk_ik, lk_ck;
  logic [IXW-1:0] rd_iix, rd_oix, rd_cix, lk_iix, lk_oix;
  assign rd_ik  = kind_t'(w_rdata[IK +: 2]);
  assign rd_ok  = kind_t'(w_rdata[OK +: 2]);
  assign rd_ck  = kind_t'(w_rdata[CK +: 2]);
  assign rd_iix = w_rdata[IIX +: IXW];
  assign rd_oix = w_rdata[OIX +: IXW];
  assign rd_cix = w_rdata[CIX +: IXW];
  assign lk_ik  = kind_t'(lk_r[IK +: 2]);
  assign lk_ck  = kind_t'(lk_r[CK +: 2]);
  assign lk_iix = lk_r[IIX +: IXW];
  assign lk_oix = lk_r[OIX +: IXW];

  logic lk_in_sum, lk_in_gin, rd_in_sum, rd_out_sum, rd_c_w, rd_c_s, last_w, last_s;
  assign rd_in_sum  = (rd_ik == KIND_SUM) && ((IXW+1)'(rd_iix) < (IXW+1)'(SUM_SLOTS));
  assign lk_in_sum  = (lk_ik == KIND_SUM) && ((IXW+1)'(lk_iix) < (IXW+1)'(SUM_SLOTS));
  assign lk_in_gin  = (lk_ik == KIND_GLOBAL) && ((IXW+1)'(lk_iix) < (IXW+1)'(INPUT_COUNT));
  assign rd_out_sum = (rd_ok == KIND_SUM) && ((IXW+1)'(rd_oix) < (IXW+1)'(SUM_SLOTS));
  assign rd_c_w = (rd_ck == KIND_WEIGHT) && ((IXW+1)'(rd_cix) < (IXW+1)'(WEIGHT_SLOTS));
  assign rd_c_s = (rd_ck == KIND_SUM) && ((IXW+1)'(rd_cix) < (IXW+1)'(SUM_SLOTS));
  assign last_w = (cnt_r == hw_r);
  assign last_s = (sc_r == hs_r);

  logic [31:0] lfsr_step;
  assign lfsr_step = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? LFSR_MASK : 32'h0);

  logic sw_in_w, sw_in_s;
  assign sw_in_w = (SWW+1)'(sw_r) < (SWW+1)'(WEIGHT_SLOTS);
  assign sw_in_s = (SWW+1)'(sw_r) < (SWW+1)'(SUM_SLOTS);

  logic signed [31:0] a_val, f_ctrl;
  logic [31:0]        e_mag;
  assign a_val  = lk_in_gin ? gin_r[lk_iix[2:0]] : (lk_in_sum ? s_rdata : wv_r);
  assign f_ctrl = (lk_ck == KIND_WEIGHT) ? v_rdata : s_rdata;
  assign e_mag  = 32'(-s_rdata);

  logic in_acc, out_free;
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    sw_nxt  = sw_r;
    cnt_nxt = cnt_r;
    sc_nxt  = sc_r;
    w_re = 1'b0; w_we = 1'b0; c_re = 1'b0; c_we = 1'b0;
    v_re = 1'b0; v_we = 1'b0; s_re = 1'b0; s_we = 1'b0;
    w_raddr = cnt_r; w_waddr = cnt_r; c_raddr = cnt_r; c_waddr = cnt_r;
    v_raddr = cnt_r; v_waddr = cnt_r; s_raddr = sc_r; s_waddr = sc_r;
    w_wdata = w_rdata; c_wdata = '0; v_wdata = '0; s_wdata = '0;
    mul_en = 1'b0; mul_a = '0; mul_b = '0;
    unique case (state_r)
      S_SWEEP: begin
        w_waddr = sw_r[WIW-1:0];
        c_waddr = sw_r[WIW-1:0];
        v_waddr = sw_r[WIW-1:0];
        s_waddr = sw_r[SIW-1:0];
        w_wdata = '0;
        c_wdata = (sw_mode_r == SW_PLAY) ? {8'b0, lfsr_step[31:8]} : 32'h0;
        w_we = sw_in_w && (sw_mode_r != SW_PLAY);
        c_we = sw_in_w && (sw_mode_r != SW_CLEAR);
        v_we = sw_in_w && (sw_mode_r != SW_CLEAR);
        s_we = sw_in_s && (sw_mode_r != SW_CLEAR);
        sw_nxt = sw_r + 1'b1;
        if (sw_r == SWW'(SWEEP_N - 1)) begin
          state_nxt = (sw_mode_r == SW_RESET) ? S_IDLE : S_FIN_RD;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN_RD;
        w_raddr   = tw_r;
        cnt_nxt   = WIW'(1);
        sc_nxt    = SIW'(1);
        sw_nxt    = '0;
        unique case (op_r)
          OP_THINK: state_nxt = S_A_RD;
          OP_SUM_TO_IN, OP_SUM_TO_CTRL: begin
            w_raddr = pw;
            if (pw_ok) begin
              w_re = 1'b1;
              state_nxt = S_B_WR;
            end
          end
          OP_WEIGHT_TO_CTRL: begin
            if (pw_ok) begin
              w_re = 1'b1;
              state_nxt = S_B_WR;
            end
          end
          OP_WEIGHT_TO_SUM: begin
            if (ps_ok) begin
              w_re = 1'b1;
              state_nxt = S_B_WR;
            end
          end
          OP_GLOBAL_TO_IN: begin
            if (gin_ok) begin
              w_re = 1'b1;
              state_nxt = S_B_WR;
            end
          end
          OP_CLEAR_BUILD, OP_START_PLAY: state_nxt = S_SWEEP;
          default: state_nxt = S_FIN_RD;
        endcase
      end
      S_B_WR: begin
        w_we = 1'b1;
        w_waddr = tw_r;
        state_nxt = S_FIN_RD;
        unique case (op_r)
          OP_SUM_TO_IN: begin
            w_waddr = pw;
            w_wdata[IK +: 2]    = KIND_SUM;
            w_wdata[IIX +: IXW] = IXW'(ts_r);
          end
          OP_SUM_TO_CTRL: begin
            w_waddr = pw;
            w_wdata[CK +: 2]    = KIND_SUM;
            w_wdata[CIX +: IXW] = IXW'(ts_r);
          end
          OP_WEIGHT_TO_SUM: begin
            w_wdata[OK +: 2]    = KIND_SUM;
            w_wdata[OIX +: IXW] = IXW'(ps);
          end
          OP_WEIGHT_TO_CTRL: begin
            w_wdata[OK +: 2]    = KIND_WEIGHT;
            w_wdata[OIX +: IXW] = IXW'(pw);
            state_nxt = S_B_RD2;
          end
          OP_GLOBAL_TO_IN: begin
            w_wdata[IK +: 2]    = KIND_GLOBAL;
            w_wdata[IIX +: IXW] = IXW'(off_r[2:0]);
          end
          default: w_we = 1'b0;
        endcase
      end
      S_B_RD2: begin
        w_re = 1'b1;
        w_raddr = pw;
        state_nxt = S_B_WR2;
      end
      S_B_WR2: begin
        w_we = 1'b1;
        w_waddr = pw;
        w_wdata[CK +: 2]    = KIND_WEIGHT;
        w_wdata[CIX +: IXW] = IXW'(tw_r);
        state_nxt = S_FIN_RD;
      end
      // load and multiply each weight
      S_A_RD: begin
        w_re = 1'b1; c_re = 1'b1; v_re = 1'b1;
        state_nxt = S_A_SRD;
      end
      S_A_SRD: begin
        s_re = rd_in_sum;
        s_raddr = rd_iix[SIW-1:0];
        state_nxt = S_A_MUL;
      end
      S_A_MUL: begin
        mul_en = 1'b1;
        mul_a = {a_val[31], a_val};
        mul_b = {coef_r[31], coef_r};
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        v_we = 1'b1;
        v_wdata = q_round(prod);
        if (last_w) begin
          state_nxt = S_C_CLR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_A_RD;
        end
      end
      // zero the used sum units
      S_C_CLR: begin
        s_we = 1'b1;
        if (last_s) begin
          sc_nxt = SIW'(1);
          cnt_nxt = WIW'(1);
          state_nxt = S_D_RD;
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      // accumulate weight outputs into their sums
      S_D_RD: begin
        w_re = 1'b1; v_re = 1'b1;
        state_nxt = S_D_SRD;
      end
      S_D_SRD: begin
        s_raddr = rd_oix[SIW-1:0];
        if (rd_out_sum) begin
          s_re = 1'b1;
          state_nxt = S_D_WR;
        end else if (last_w) begin
          state_nxt = S_E_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_D_RD;
        end
      end
      S_D_WR: begin
        s_we = 1'b1;
        s_waddr = lk_oix[SIW-1:0];
        s_wdata = sat_add(s_rdata, wv_r);
        if (last_w) begin
          state_nxt = S_E_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_D_RD;
        end
      end
      // leak: negative sums divided by ten, toward zero
      S_E_RD: begin
        s_re = 1'b1;
        state_nxt = S_E_MUL;
      end
      S_E_MUL: begin
        mul_en = 1'b1;
        mul_a = {1'b0, e_mag};
        mul_b = {1'b0, DIV10_RECIP};
        state_nxt = S_E_WR;
      end
      S_E_WR: begin
        s_we = neg_r;
        s_wdata = 32'(-(prod >>> DIV10_SHIFT));
        if (last_s) begin
          cnt_nxt = WIW'(1);
          state_nxt = S_F_RD;
        end else begin
          sc_nxt = sc_r + 1'b1;
          state_nxt = S_E_RD;
        end
      end
      // coefficient learning
      S_F_RD: begin
        w_re = 1'b1; c_re = 1'b1;
        state_nxt = S_F_XRD;
      end
      S_F_XRD: begin
        v_raddr = rd_cix[WIW-1:0];
        s_raddr = rd_cix[SIW-1:0];
        if (rd_c_w) begin
          v_re = 1'b1;
          state_nxt = S_F_MUL;
        end else if (rd_c_s) begin
          s_re = 1'b1;
          state_nxt = S_F_MUL;
        end else if (last_w) begin
          state_nxt = S_FIN_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_F_RD;
        end
      end
      S_F_MUL: begin
        mul_en = 1'b1;
        mul_a = {f_ctrl[31], f_ctrl};
        mul_b = signed'(33'(lr_r));
        state_nxt = S_F_RND;
      end
      S_F_RND: state_nxt = S_F_WR;
      S_F_WR: begin
        c_we = 1'b1;
        c_wdata = sat_add(coef_r, q_r);
        if (last_w) begin
          state_nxt = S_FIN_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_F_RD;
        end
      end
      S_FIN_RD: begin
        s_re = 1'b1;
        s_raddr = rs_r;
        state_nxt = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_SWEEP;
      sw_mode_r <= SW_RESET;
      sw_r      <= '0;
      cnt_r     <= WIW'(1);
      sc_r      <= SIW'(1);
    end else begin
      state_r <= state_nxt;
      sw_r    <= sw_nxt;
      cnt_r   <= cnt_nxt;
      sc_r    <= sc_nxt;
      if (state_r == S_DISP) begin
        sw_mode_r <= (op_r == OP_START_PLAY) ? SW_PLAY : SW_CLEAR;
      end
    end
  end

  // build state, registers and generator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r   <= WIW'(1);
      hw_r   <= WIW'(1);
      ts_r   <= SIW'(1);
      hs_r   <= SIW'(1);
      rs_r   <= '0;
      lr_r   <= LR_RESET;
      lfsr_r <= 32'd1;
    end else begin
      if (cfg_we && cfg_index == CFG_LEARNING_RATE) begin
        lr_r <= cfg_wdata[LR_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_RANDOM_SEED) begin
        lfsr_r <= (cfg_wdata == 32'h0) ? 32'd1 : cfg_wdata;
      end else if (state_r == S_SWEEP && sw_mode_r == SW_PLAY && sw_in_w) begin
        lfsr_r <= lfsr_step;
      end
      if (state_r == S_DISP) begin
        unique case (op_r)
          OP_NEW_WEIGHT: begin
            if ((WIW+1)'(tw_r) + 1'b1 < (WIW+1)'(WEIGHT_SLOTS)) begin
              tw_r <= tw_r + 1'b1;
              if (tw_r + 1'b1 > hw_r) hw_r <= tw_r + 1'b1;
            end
          end
          OP_NEW_SUM: begin
            if ((SIW+1)'(ts_r) + 1'b1 < (SIW+1)'(SUM_SLOTS)) begin
              ts_r <= ts_r + 1'b1;
              if (ts_r + 1'b1 > hs_r) hs_r <= ts_r + 1'b1;
            end
          end
          OP_POP_WEIGHT: if (tw_r > WIW'(1)) tw_r <= tw_r - 1'b1;
          OP_POP_SUM:    if (ts_r > SIW'(1)) ts_r <= ts_r - 1'b1;
          OP_SUM_TO_RESULT: rs_r <= ts_r;
          OP_CLEAR_BUILD: begin
            tw_r <= WIW'(1);
            hw_r <= WIW'(1);
            ts_r <= SIW'(1);
            hs_r <= SIW'(1);
            rs_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // item payload, status and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_chan.op;
      off_r    <= in_chan.offset;
      gin_r[0] <= in_chan.red_x;
      gin_r[1] <= in_chan.red_y;
      gin_r[2] <= in_chan.blue_x;
      gin_r[3] <= in_chan.blue_y;
      gin_r[4] <= in_chan.query_x;
      gin_r[5] <= in_chan.query_y;
      gin_r[6] <= in_chan.energy;
      status_r <= ST_OK;
    end
    if (state_r == S_DISP) begin
      unique case (op_r)
        OP_THINK, OP_SUM_TO_IN, OP_SUM_TO_CTRL, OP_WEIGHT_TO_SUM,
        OP_WEIGHT_TO_CTRL, OP_POP_WEIGHT, OP_POP_SUM, OP_SUM_TO_RESULT,
        OP_CLEAR_BUILD, OP_START_PLAY: status_r <= ST_OK;
        OP_NEW_WEIGHT: begin
          if ((WIW+1)'(tw_r) + 1'b1 >= (WIW+1)'(WEIGHT_SLOTS)) status_r <= ST_WEIGHT_FULL;
        end
        OP_NEW_SUM: begin
          if ((SIW+1)'(ts_r) + 1'b1 >= (SIW+1)'(SUM_SLOTS)) status_r <= ST_SUM_FULL;
        end
        OP_GLOBAL_TO_IN: if (!gin_ok) status_r <= ST_INDEX_RANGE;
        default: status_r <= ST_UNKNOWN_OP;
      endcase
    end
    if (state_r == S_A_SRD || state_r == S_F_XRD) begin
      lk_r   <= w_rdata;
      coef_r <= c_rdata;
      wv_r   <= v_rdata;
    end
    if (state_r == S_D_SRD) begin
      lk_r <= w_rdata;
      wv_r <= v_rdata;
    end
    if (state_r == S_E_MUL) begin
      neg_r <= s_rdata[31];
    end
    if (state_r == S_F_RND) begin
      q_r <= q_round(prod);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN_OUT && out_free) begin
      out_value_r  <= s_rdata;
      out_status_r <= status_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_value = out_value_r;
  assign out_chan.status    = out_status_r;

endmodule
`default_nettype wire

>>> rtl/gbn_chk.sv
// Port-level checker for the step engine, bound to the top level.
`default_nettype none
module gbn_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] status,
  input wire logic [31:0] out_value
);
  import gbn_pkg::*;

  // one item at a time: a command transfer closes the input until done
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // clearing pass follows reset
  a_sweep_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !in_ready)
    else $error("input open during clearing pass");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= ST_UNKNOWN_OP)
    else $error("status code out of range");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(status))
    else $error("stalled result changed");
endmodule

bind gene_built_net_step_engine_top gbn_chk u_gbn_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_chan.valid), .in_ready(in_chan.ready),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .status(out_chan.status), .out_value(out_chan.out_value)
);
`default_nettype wire
